### rtl/odo_pkg.sv
// Shared types, constants and the arctangent table for the odometry block.
// No dependencies.
package odo_pkg;

  localparam int DELTA_W = 24;
  localparam int CORD_W  = 34;
  localparam logic [31:0] CORDIC_X0 = 32'h26DD3B6A;
  localparam logic cfg_addr_heading = 1'b0;

  typedef enum logic [1:0] {
    REG_HEADING_GAIN  = 2'd0,
    REG_DISTANCE_GAIN = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_GAIN_H, ST_GAIN_D, ST_ROT, ST_QUAD, ST_MUL, ST_DONE
  } back_st_t;

  typedef struct packed {
    logic                      mode;
    logic signed [DELTA_W-1:0] dl;
    logic signed [DELTA_W-1:0] dr;
  } odo_item_t;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

endpackage

### rtl/odo_if.sv
// Valid/ready channel interfaces for encoder items and pose results.
// No dependencies.
interface odo_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] left_count;
  logic signed [31:0] right_count;
  modport source (output valid, mode, left_count, right_count, input ready);
  modport sink   (input valid, mode, left_count, right_count, output ready);
endinterface

interface odo_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic        [31:0] heading_angle;
  modport source (output valid, pos_x, pos_y, heading_angle, input ready);
  modport sink   (input valid, pos_x, pos_y, heading_angle, output ready);
endinterface

### rtl/odo_front.sv
// Front end: accepts encoder items, forms saturated tick deltas.
// Depends on odo_pkg and odo_in_if.
module odo_front (
  input  logic              clk,
  input  logic              rst_n,
  odo_in_if.sink            in_chan,
  input  logic              q_full,
  output logic              q_push,
  output odo_pkg::odo_item_t q_data
);
  import odo_pkg::*;

  logic [31:0] prev_left_r, prev_right_r;
  logic [31:0] neg_l, neg_r, diff_l, diff_r;

  function automatic logic signed [DELTA_W-1:0] sat(input logic [31:0] d);
    logic signed [31:0] s;
    s = signed'(d);
    if (s > 32'sd8388607) return {1'b0, {(DELTA_W-1){1'b1}}};
    if (s < -32'sd8388608) return {1'b1, {(DELTA_W-1){1'b0}}};
    return s[DELTA_W-1:0];
  endfunction

  assign in_chan.ready = !q_full;
  assign q_push = in_chan.valid && !q_full;
  assign neg_l  = 32'd0 - in_chan.left_count;
  assign neg_r  = 32'd0 - in_chan.right_count;
  assign diff_l = neg_l - prev_left_r;
  assign diff_r = neg_r - prev_right_r;

  always_comb begin
    q_data.mode = in_chan.mode;
    q_data.dl   = sat(diff_l);
    q_data.dr   = sat(diff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_left_r  <= '0;
      prev_right_r <= '0;
    end else if (q_push) begin
      if (in_chan.mode) begin
        prev_left_r  <= '0;
        prev_right_r <= '0;
      end else begin
        prev_left_r  <= neg_l;
        prev_right_r <= neg_r;
      end
    end
  end
endmodule

### rtl/odo_queue.sv
// Two-entry queue between the front and back ends.
// Depends on odo_pkg.
module odo_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  odo_pkg::odo_item_t push_data,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output odo_pkg::odo_item_t head
);
  import odo_pkg::*;

  odo_item_t mem_r [2];
  logic      wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

### rtl/odo_back.sv
// Back end: heading update, iterative CORDIC, shared multiplier, position.
// Depends on odo_pkg and odo_out_if.
module odo_back #(
  parameter int POS_BITS   = 48,
  parameter int ANGLE_BITS = 32,
  parameter int TRIG_ITERS = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        heading_gain,
  input  logic [31:0]        distance_gain,
  input  logic               q_valid,
  input  odo_pkg::odo_item_t q_head,
  output logic               q_pop,
  odo_out_if.source          out_chan
);
  import odo_pkg::*;

  back_st_t st_r, st_nxt;
  logic signed [DELTA_W:0]     dd_r, ds_r;
  logic [ANGLE_BITS-1:0]       heading_r;
  logic signed [57:0]          step_r;
  logic signed [CORD_W-1:0]    x_r, y_r, z_r, c_r, s_r;
  logic [5:0]                  it_r;
  logic [2:0]                  mc_r;
  logic [1:0]                  q_r;
  logic signed [64:0]          prod_r;
  logic [POS_BITS-1:0]         x_acc_r, y_acc_r;
  logic                        ov_r;
  logic signed [47:0]          ox_r, oy_r;
  logic [31:0]                 oh_r;

  logic [31:0]              dd32, a32, ru;
  logic [1:0]               qd;
  logic signed [CORD_W-1:0] xs, ys, atk;
  logic signed [30:0]       ma;
  logic signed [CORD_W-1:0] mb;
  logic [1:0]               pidx;
  logic [POS_BITS-1:0]      addend;
  logic                     slot_free;

  assign dd32 = 32'(dd_r);
  assign a32  = 32'(heading_r) << (32 - ANGLE_BITS);
  assign qd   = 2'((a32 + 32'h20000000) >> 30);
  assign ru   = a32 - {qd, 30'b0};
  assign xs   = x_r >>> it_r[4:0];
  assign ys   = y_r >>> it_r[4:0];
  assign atk  = CORD_W'(ATAN_TURNS[it_r[4:0]]);
  assign ma   = mc_r[0] ? 31'(step_r >>> 30) : {1'b0, step_r[29:0]};
  assign mb   = mc_r[1] ? s_r : c_r;
  assign pidx = 2'(mc_r - 3'd1);
  assign addend = pidx[0] ? POS_BITS'(prod_r) : POS_BITS'(prod_r >>> 30);
  assign slot_free = !ov_r || out_chan.ready;

  assign q_pop = (st_r == ST_IDLE) && q_valid;
  assign out_chan.valid         = ov_r;
  assign out_chan.pos_x         = ox_r;
  assign out_chan.pos_y         = oy_r;
  assign out_chan.heading_angle = oh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE:   if (q_valid) st_nxt = q_head.mode ? ST_DONE : ST_GAIN_H;
      ST_GAIN_H: st_nxt = ST_GAIN_D;
      ST_GAIN_D: st_nxt = ST_ROT;
      ST_ROT:    if (it_r == 6'(TRIG_ITERS - 1)) st_nxt = ST_QUAD;
      ST_QUAD:   st_nxt = ST_MUL;
      ST_MUL:    if (mc_r == 3'd4) st_nxt = ST_DONE;
      ST_DONE:   if (slot_free) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_r <= '0;
      x_acc_r   <= '0;
      y_acc_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      ov_r <= (ov_r && !out_chan.ready) || ((st_r == ST_DONE) && slot_free);
      case (st_r)
        ST_IDLE: if (q_valid && q_head.mode) begin
          heading_r <= '0;
          x_acc_r   <= '0;
          y_acc_r   <= '0;
        end
        ST_GAIN_H: heading_r <= heading_r + ANGLE_BITS'(heading_gain * dd32);
        ST_MUL: if (mc_r != 3'd0) begin
          if (pidx[1]) y_acc_r <= y_acc_r + addend;
          else         x_acc_r <= x_acc_r + addend;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        dd_r   <= (DELTA_W+1)'(q_head.dl) - (DELTA_W+1)'(q_head.dr);
        ds_r   <= (DELTA_W+1)'(q_head.dl) + (DELTA_W+1)'(q_head.dr);
      end
      ST_GAIN_D: begin
        step_r <= 58'(signed'({1'b0, distance_gain}) * ds_r);
        q_r    <= qd;
        x_r    <= CORD_W'(CORDIC_X0);
        y_r    <= '0;
        it_r   <= '0;
      end
      ST_ROT: begin
        if (z_r[CORD_W-1]) begin
          x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atk;
        end else begin
          x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atk;
        end
        it_r <= it_r + 6'd1;
      end
      ST_QUAD: begin
        mc_r <= '0;
        case (q_r)
          2'd0:    begin c_r <= x_r;  s_r <= y_r;  end
          2'd1:    begin c_r <= -y_r; s_r <= x_r;  end
          2'd2:    begin c_r <= -x_r; s_r <= -y_r; end
          default: begin c_r <= y_r;  s_r <= -x_r; end
        endcase
      end
      ST_MUL: begin
        prod_r <= 65'(ma * mb);
        mc_r   <= mc_r + 3'd1;
      end
      ST_DONE: if (slot_free) begin
        ox_r <= 48'(signed'(x_acc_r));
        oy_r <= 48'(signed'(y_acc_r));
        oh_r <= 32'(heading_r);
      end
      default: ;
    endcase
    if (st_r == ST_GAIN_D) z_r <= CORD_W'(signed'(ru));
  end
endmodule

### rtl/differential_drive_odometry.sv
// Top level of the differential-drive odometry block.
// Depends on odo_pkg, odo_if, odo_front, odo_queue and odo_back.
//
//  channel   dir  handshake        payload
//  in_chan   in   valid/ready      mode, left_count, right_count
//  out_chan  out  valid/ready      pos_x, pos_y, heading_angle
//  cfg_*     in   APB write/read   heading_gain @0x0, distance_gain @0x4
//
// An update item runs the gain, CORDIC, quadrant and multiply states of the
// back end (one-iteration-per-cycle CORDIC, four shared-multiplier passes); a
// reset item goes from idle to done. The front end takes an item per cycle
// into a two-entry queue while not full. Reset is synchronous, active low,
// clears all but the datapath. A stalled result holds in the output register.
module differential_drive_odometry #(
  parameter int POS_BITS   = 48,
  parameter int ANGLE_BITS = 32,
  parameter int TRIG_ITERS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  odo_in_if.sink      in_chan,
  odo_out_if.source   out_chan,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import odo_pkg::*;

  logic [31:0] heading_gain_r, distance_gain_r;
  logic        q_push, q_pop, q_full, q_valid;
  odo_item_t   q_in, q_head;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == cfg_addr_heading) ? heading_gain_r : distance_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heading_gain_r  <= '0;
      distance_gain_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == cfg_addr_heading) heading_gain_r  <= cfg_pwdata;
      else                                  distance_gain_r <= cfg_pwdata;
    end
  end

  odo_front u_front (
    .clk, .rst_n, .in_chan, .q_full, .q_push, .q_data(q_in)
  );

  odo_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
    .full(q_full), .not_empty(q_valid), .head(q_head)
  );

  odo_back #(
    .POS_BITS(POS_BITS), .ANGLE_BITS(ANGLE_BITS), .TRIG_ITERS(TRIG_ITERS)
  ) u_back (
    .clk, .rst_n, .heading_gain(heading_gain_r), .distance_gain(distance_gain_r),
    .q_valid, .q_head, .q_pop, .out_chan
  );
endmodule

### rtl/odo_chk.sv
// Port-level checks for the odometry block, bound to the top level.
// Depends on differential_drive_odometry.
module odo_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_heading,
  input logic        cfg_pready
);
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_heading))
    else $error("stalled result changed");
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready dropped");
endmodule

bind differential_drive_odometry odo_chk u_odo_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_chan.valid), .out_ready(out_chan.ready),
  .out_heading(out_chan.heading_angle), .cfg_pready(cfg_pready)
);
